### hdl/decimal_count_rle_grid_decoder_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the run-length grid decoder
// Implication and next-cycle checks, clocked and reset-gated.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_COUNT_RLE_GRID_DECODER_DEFINES_SVH
`define DECIMAL_COUNT_RLE_GRID_DECODER_DEFINES_SVH

// same-cycle implication
`define DCRLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcrle check failed");

// next-cycle implication
`define DCRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcrle check failed");

`endif

### hdl/dcrle_pkg.sv
// ---------------------------------------------------------------------------
// dcrle_pkg
// Types, constants and microprogram for the run-length grid decoder.
// ---------------------------------------------------------------------------
package dcrle_pkg;

  localparam int RowW = 9;
  localparam int ColW = 11;
  localparam int CntW = 6;
  localparam int UpcW = 4;

  localparam logic [CntW-1:0] MaxRun     = 6'd32;
  localparam logic [RowW-1:0] MaxRows    = 9'd256;
  localparam logic [ColW-1:0] MaxColumns = 11'd1024;

  localparam logic [7:0] BarChar  = 8'h7C;
  localparam logic [7:0] SemiChar = 8'h3B;

  localparam logic [1:0] KindCell  = 2'd0;
  localparam logic [1:0] KindRow   = 2'd1;
  localparam logic [1:0] KindLevel = 2'd2;

  // microprogram addresses
  localparam logic [UpcW-1:0] AddrFetch   = 4'd0;
  localparam logic [UpcW-1:0] AddrBar     = 4'd1;
  localparam logic [UpcW-1:0] AddrSemiRow = 4'd2;
  localparam logic [UpcW-1:0] AddrSemiLvl = 4'd3;
  localparam logic [UpcW-1:0] AddrDigit   = 4'd4;
  localparam logic [UpcW-1:0] AddrLoad    = 4'd5;
  localparam logic [UpcW-1:0] AddrCell    = 4'd6;
  localparam logic [UpcW-1:0] AddrEndRow  = 4'd7;
  localparam logic [UpcW-1:0] AddrEndLvl  = 4'd8;
  localparam logic [UpcW-1:0] AddrClear   = 4'd9;

  typedef enum logic [2:0] {
    ACT_FETCH, ACT_ROW, ACT_LEVEL, ACT_DIGIT, ACT_LOAD, ACT_CELL, ACT_CLEAR
  } act_t;

  typedef enum logic [2:0] {
    G_ALWAYS, G_COL_NZ, G_RUN_NZ, G_END, G_END_LIVE, G_END_LIVE_COL
  } guard_t;

  typedef enum logic [1:0] {
    LAST_NEVER, LAST_ALWAYS, LAST_NOT_END, LAST_CELL
  } last_t;

  typedef enum logic [2:0] {
    CLS_TERM, CLS_BAR, CLS_SEMI, CLS_DIGIT, CLS_SYM
  } cls_t;

  typedef struct packed {
    act_t            act;
    guard_t          guard;
    last_t           last;
    logic            loop;
    logic [UpcW-1:0] next;
  } uword_t;

  typedef struct packed {
    act_t  act;
    last_t last;
    logic  fire;
    logic  accept;
  } ctrl_t;

  typedef struct packed {
    cls_t cls;
    logic col_nz;
    logic run_nz;
    logic end_flag;
    logic term;
    logic out_free;
  } stat_t;

  function automatic uword_t ucode_rom(input logic [UpcW-1:0] addr);
    uword_t w;
    case (addr)
      AddrFetch:   w = '{ACT_FETCH, G_ALWAYS,       LAST_NEVER,   1'b0, AddrFetch};
      AddrBar:     w = '{ACT_ROW,   G_ALWAYS,       LAST_NOT_END, 1'b0, AddrEndRow};
      AddrSemiRow: w = '{ACT_ROW,   G_COL_NZ,       LAST_NEVER,   1'b0, AddrSemiLvl};
      AddrSemiLvl: w = '{ACT_LEVEL, G_ALWAYS,       LAST_ALWAYS,  1'b0, AddrEndRow};
      AddrDigit:   w = '{ACT_DIGIT, G_ALWAYS,       LAST_NEVER,   1'b0, AddrEndRow};
      AddrLoad:    w = '{ACT_LOAD,  G_ALWAYS,       LAST_NEVER,   1'b0, AddrCell};
      AddrCell:    w = '{ACT_CELL,  G_RUN_NZ,       LAST_CELL,    1'b1, AddrEndRow};
      AddrEndRow:  w = '{ACT_ROW,   G_END_LIVE_COL, LAST_NEVER,   1'b0, AddrEndLvl};
      AddrEndLvl:  w = '{ACT_LEVEL, G_END_LIVE,     LAST_ALWAYS,  1'b0, AddrClear};
      AddrClear:   w = '{ACT_CLEAR, G_END,          LAST_NEVER,   1'b0, AddrFetch};
      default:     w = '{ACT_CLEAR, G_END,          LAST_NEVER,   1'b0, AddrFetch};
    endcase
    return w;
  endfunction

  function automatic logic [UpcW-1:0] dispatch(input cls_t cls);
    logic [UpcW-1:0] a;
    case (cls)
      CLS_TERM:  a = AddrClear;
      CLS_BAR:   a = AddrBar;
      CLS_SEMI:  a = AddrSemiRow;
      CLS_DIGIT: a = AddrDigit;
      CLS_SYM:   a = AddrLoad;
      default:   a = AddrClear;
    endcase
    return a;
  endfunction

endpackage

### hdl/dcrle_in_if.sv
// ---------------------------------------------------------------------------
// dcrle_in_if
// Input channel: one encoded byte per request.
// ---------------------------------------------------------------------------
interface dcrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       string_end;

  modport source(output valid, code_byte, string_end, input ready);
  modport sink(input valid, code_byte, string_end, output ready);
endinterface

### hdl/dcrle_out_if.sv
// ---------------------------------------------------------------------------
// dcrle_out_if
// Result channel: one grid cell, row end or level end per request.
// ---------------------------------------------------------------------------
interface dcrle_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  cell_symbol;
  logic [8:0]  row_number;
  logic [10:0] column_number;
  logic        overflow_flag;
  logic        run_last;

  modport source(output valid, result_kind, cell_symbol, row_number, column_number,
                 overflow_flag, run_last, input ready);
  modport sink(input valid, result_kind, cell_symbol, row_number, column_number,
               overflow_flag, run_last, output ready);
endinterface

### hdl/dcrle_useq.sv
// ---------------------------------------------------------------------------
// dcrle_useq
// Microcode sequencer: step counter, control ROM, guards and jumps.
// ---------------------------------------------------------------------------
module dcrle_useq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dcrle_pkg::stat_t     stat,
  output dcrle_pkg::ctrl_t     ctrl
);

  logic [dcrle_pkg::UpcW-1:0] upc_r, upc_nxt;
  dcrle_pkg::uword_t          uw;
  logic                       guard_ok;
  logic                       needs_out;
  logic                       fire;

  assign uw = dcrle_pkg::ucode_rom(upc_r);

  always_comb begin
    case (uw.guard)
      dcrle_pkg::G_ALWAYS:       guard_ok = 1'b1;
      dcrle_pkg::G_COL_NZ:       guard_ok = stat.col_nz;
      dcrle_pkg::G_RUN_NZ:       guard_ok = stat.run_nz;
      dcrle_pkg::G_END:          guard_ok = stat.end_flag;
      dcrle_pkg::G_END_LIVE:     guard_ok = stat.end_flag && !stat.term;
      dcrle_pkg::G_END_LIVE_COL: guard_ok = stat.end_flag && !stat.term && stat.col_nz;
      default:                   guard_ok = 1'b0;
    endcase
  end

  assign needs_out = (uw.act == dcrle_pkg::ACT_ROW) || (uw.act == dcrle_pkg::ACT_LEVEL) ||
                     (uw.act == dcrle_pkg::ACT_CELL);
  assign fire = (uw.act != dcrle_pkg::ACT_FETCH) && guard_ok &&
                (!needs_out || stat.out_free);

  // outputs
  always_comb begin
    in_ready    = (uw.act == dcrle_pkg::ACT_FETCH);
    ctrl.act    = uw.act;
    ctrl.last   = uw.last;
    ctrl.fire   = fire;
    ctrl.accept = in_ready && in_valid;
  end

  // next step
  always_comb begin
    upc_nxt = upc_r;
    if (uw.act == dcrle_pkg::ACT_FETCH) begin
      if (in_valid) begin
        upc_nxt = dcrle_pkg::dispatch(stat.cls);
      end
    end else if (!guard_ok) begin
      upc_nxt = uw.next;
    end else if (fire && !uw.loop) begin
      upc_nxt = uw.next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= dcrle_pkg::AddrFetch;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

### hdl/dcrle_dpath.sv
// ---------------------------------------------------------------------------
// dcrle_dpath
// Decoder datapath: count, row and column registers, result register.
// ---------------------------------------------------------------------------
module dcrle_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_code_byte,
  input  logic                 in_string_end,
  input  dcrle_pkg::ctrl_t     ctrl,
  output dcrle_pkg::stat_t     stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [1:0]           out_result_kind,
  output logic [7:0]           out_cell_symbol,
  output logic [8:0]           out_row_number,
  output logic [10:0]          out_column_number,
  output logic                 out_overflow_flag,
  output logic                 out_run_last
);

  logic [7:0]                 byte_r, byte_nxt;
  logic                       end_r, end_nxt;
  logic [dcrle_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic                       dig_r, dig_nxt;
  logic [dcrle_pkg::CntW-1:0] run_r, run_nxt;
  logic [dcrle_pkg::RowW-1:0] row_r, row_nxt;
  logic [dcrle_pkg::ColW-1:0] col_r, col_nxt;
  logic                       term_r, term_nxt;

  logic                       ov_r, ov_nxt;
  logic [1:0]                 kind_r, kind_nxt;
  logic [7:0]                 sym_r, sym_nxt;
  logic [dcrle_pkg::RowW-1:0] orow_r, orow_nxt;
  logic [dcrle_pkg::ColW-1:0] ocol_r, ocol_nxt;
  logic                       oflag_r, oflag_nxt;
  logic                       olast_r, olast_nxt;

  logic                       is_digit;
  logic [9:0]                 cnt10;
  logic                       last_bit;
  logic                       out_free;

  assign is_digit = (in_code_byte >= 8'h30) && (in_code_byte <= 8'h39);
  assign out_free = !ov_r || out_ready;
  assign cnt10 = {1'b0, cnt_r, 3'b000} + {3'b000, cnt_r, 1'b0} + {6'd0, byte_r[3:0]};

  always_comb begin
    if (term_r) begin
      stat.cls = dcrle_pkg::CLS_TERM;
    end else if (in_code_byte == dcrle_pkg::BarChar) begin
      stat.cls = dcrle_pkg::CLS_BAR;
    end else if (in_code_byte == dcrle_pkg::SemiChar) begin
      stat.cls = dcrle_pkg::CLS_SEMI;
    end else if (is_digit) begin
      stat.cls = dcrle_pkg::CLS_DIGIT;
    end else begin
      stat.cls = dcrle_pkg::CLS_SYM;
    end
    stat.col_nz   = (col_r != '0);
    stat.run_nz   = (run_r != '0);
    stat.end_flag = end_r;
    stat.term     = term_r;
    stat.out_free = out_free;
  end

  always_comb begin
    case (ctrl.last)
      dcrle_pkg::LAST_NEVER:   last_bit = 1'b0;
      dcrle_pkg::LAST_ALWAYS:  last_bit = 1'b1;
      dcrle_pkg::LAST_NOT_END: last_bit = !end_r;
      dcrle_pkg::LAST_CELL:    last_bit = (run_r == dcrle_pkg::CntW'(1)) && !end_r;
      default:                 last_bit = 1'b0;
    endcase
  end

  always_comb begin
    byte_nxt  = byte_r;
    end_nxt   = end_r;
    cnt_nxt   = cnt_r;
    dig_nxt   = dig_r;
    run_nxt   = run_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    term_nxt  = term_r;
    ov_nxt    = ov_r && !out_ready;
    kind_nxt  = kind_r;
    sym_nxt   = sym_r;
    orow_nxt  = orow_r;
    ocol_nxt  = ocol_r;
    oflag_nxt = oflag_r;
    olast_nxt = olast_r;
    if (ctrl.accept) begin
      byte_nxt = in_code_byte;
      end_nxt  = in_string_end;
    end
    if (ctrl.fire) begin
      case (ctrl.act)
        dcrle_pkg::ACT_ROW: begin
          ov_nxt    = 1'b1;
          kind_nxt  = dcrle_pkg::KindRow;
          sym_nxt   = 8'd0;
          orow_nxt  = (row_r >= dcrle_pkg::MaxRows) ? dcrle_pkg::MaxRows : row_r;
          ocol_nxt  = (col_r > dcrle_pkg::MaxColumns) ? dcrle_pkg::MaxColumns : col_r;
          oflag_nxt = (row_r >= dcrle_pkg::MaxRows) || (col_r > dcrle_pkg::MaxColumns);
          olast_nxt = last_bit;
          if (row_r <= dcrle_pkg::MaxRows) begin
            row_nxt = row_r + 1'b1;
          end
          col_nxt = '0;
          cnt_nxt = '0;
          dig_nxt = 1'b0;
        end
        dcrle_pkg::ACT_LEVEL: begin
          ov_nxt    = 1'b1;
          kind_nxt  = dcrle_pkg::KindLevel;
          sym_nxt   = 8'd0;
          orow_nxt  = (row_r > dcrle_pkg::MaxRows) ? dcrle_pkg::MaxRows : row_r;
          ocol_nxt  = '0;
          oflag_nxt = (row_r > dcrle_pkg::MaxRows);
          olast_nxt = last_bit;
          term_nxt  = 1'b1;
          cnt_nxt   = '0;
          dig_nxt   = 1'b0;
        end
        dcrle_pkg::ACT_DIGIT: begin
          cnt_nxt = (cnt10 > {4'd0, dcrle_pkg::MaxRun}) ? dcrle_pkg::MaxRun
                                                        : cnt10[dcrle_pkg::CntW-1:0];
          dig_nxt = 1'b1;
        end
        dcrle_pkg::ACT_LOAD: begin
          run_nxt = dig_r ? cnt_r : dcrle_pkg::CntW'(1);
          cnt_nxt = '0;
          dig_nxt = 1'b0;
        end
        dcrle_pkg::ACT_CELL: begin
          ov_nxt    = 1'b1;
          kind_nxt  = dcrle_pkg::KindCell;
          sym_nxt   = byte_r;
          orow_nxt  = (row_r >= dcrle_pkg::MaxRows) ? dcrle_pkg::MaxRows : row_r;
          ocol_nxt  = (col_r >= dcrle_pkg::MaxColumns) ? dcrle_pkg::MaxColumns : col_r;
          oflag_nxt = (row_r >= dcrle_pkg::MaxRows) || (col_r >= dcrle_pkg::MaxColumns);
          olast_nxt = last_bit;
          if (col_r <= dcrle_pkg::MaxColumns) begin
            col_nxt = col_r + 1'b1;
          end
          run_nxt = run_r - 1'b1;
        end
        dcrle_pkg::ACT_CLEAR: begin
          cnt_nxt  = '0;
          dig_nxt  = 1'b0;
          row_nxt  = '0;
          col_nxt  = '0;
          term_nxt = 1'b0;
        end
        default: begin
          ov_nxt = ov_r && !out_ready;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      dig_r  <= 1'b0;
      run_r  <= '0;
      row_r  <= '0;
      col_r  <= '0;
      term_r <= 1'b0;
      end_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      dig_r  <= dig_nxt;
      run_r  <= run_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      term_r <= term_nxt;
      end_r  <= end_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    kind_r  <= kind_nxt;
    sym_r   <= sym_nxt;
    orow_r  <= orow_nxt;
    ocol_r  <= ocol_nxt;
    oflag_r <= oflag_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid         = ov_r;
  assign out_result_kind   = kind_r;
  assign out_cell_symbol   = sym_r;
  assign out_row_number    = orow_r;
  assign out_column_number = ocol_r;
  assign out_overflow_flag = oflag_r;
  assign out_run_last      = olast_r;

endmodule

### hdl/decimal_count_rle_grid_decoder.sv
// ---------------------------------------------------------------------------
// decimal_count_rle_grid_decoder
// Run-length text decoder producing grid cells, row ends and level ends.
// ---------------------------------------------------------------------------
// One byte is taken per request and run through a short microprogram; the
// next byte is taken only when that program returns to its fetch step. A
// symbol emits as many cells as the count before it, or one without a count,
// at most 32 with the run limit of 32; the cell loop of the sequencer emits
// one cell per cycle while the result register is free or being read. Every
// step that writes a result waits while the result register is still full.
// The last result of a byte is marked with run_last.
module decimal_count_rle_grid_decoder (
  input  logic               clk,
  input  logic               rst_n,
  dcrle_in_if.sink           in_ch,
  dcrle_out_if.source        out_ch
);

  dcrle_pkg::ctrl_t ctrl;
  dcrle_pkg::stat_t stat;

  dcrle_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  dcrle_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_code_byte      (in_ch.code_byte),
    .in_string_end     (in_ch.string_end),
    .ctrl              (ctrl),
    .stat              (stat),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_result_kind   (out_ch.result_kind),
    .out_cell_symbol   (out_ch.cell_symbol),
    .out_row_number    (out_ch.row_number),
    .out_column_number (out_ch.column_number),
    .out_overflow_flag (out_ch.overflow_flag),
    .out_run_last      (out_ch.run_last)
  );

endmodule

### hdl/dcrle_checker.sv
// ---------------------------------------------------------------------------
// dcrle_checker
// Port-level checks for the run-length grid decoder, bound to the top.
// ---------------------------------------------------------------------------
`include "decimal_count_rle_grid_decoder_defines.svh"

module dcrle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_result_kind,
  input logic [7:0]  out_cell_symbol,
  input logic [8:0]  out_row_number,
  input logic [10:0] out_column_number,
  input logic        out_overflow_flag,
  input logic        out_run_last
);

  logic [31:0] payload;

  assign payload = {out_result_kind, out_cell_symbol, out_row_number, out_column_number,
                    out_overflow_flag, out_run_last};

  `DCRLE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `DCRLE_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(payload))
  // more results of the same request pending: no new request taken
  `DCRLE_ASSERT_IMPL(a_busy_mid_run, clk, rst_n, out_valid && !out_run_last, !in_ready)
  `DCRLE_ASSERT_IMPL(a_sym_zero, clk, rst_n,
                     out_valid && (out_result_kind != dcrle_pkg::KindCell),
                     out_cell_symbol == 8'd0)

endmodule

bind decimal_count_rle_grid_decoder dcrle_checker u_dcrle_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_result_kind   (out_ch.result_kind),
  .out_cell_symbol   (out_ch.cell_symbol),
  .out_row_number    (out_ch.row_number),
  .out_column_number (out_ch.column_number),
  .out_overflow_flag (out_ch.overflow_flag),
  .out_run_last      (out_ch.run_last)
);
